FILE: rtl/lsps_pkg.sv
// Shared widths, reset values, register indexes and constants of the line-sensor steering core.
package lsps_pkg;

  // Field widths fixed by the item formats.
  localparam int SAMPLE_W = 10;
  localparam int POS_W = 4;
  localparam int SUM_W = 6;
  localparam int TOTAL_W = 24;
  localparam int GAIN_W = 16;
  localparam int BASE_W = 10;

  // Configuration port.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_DUTY = 3'd4;

  localparam logic [SAMPLE_W-1:0] WHITE_THRESHOLD_RESET = 10'd400;
  localparam logic [GAIN_W-1:0] PROP_GAIN_RESET = 16'd256;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RESET = 16'd28000;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RESET = 16'd0;
  localparam logic [BASE_W-1:0] BASE_DUTY_RESET = 10'd375;

  // Sensor array geometry and controller constants.
  localparam int NUM_SENSORS = 13;
  localparam int CENTER = (NUM_SENSORS - 1) / 2;
  localparam int DIVISOR = 13;
  localparam int DUTY_BITS = 10;

endpackage

FILE: rtl/lsps_if.sv
// Valid/ready stream interfaces for the sample channel and the result channel.
interface lsps_smp_if;
  import lsps_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic [POS_W-1:0]    sensor_pos;
  logic                frame_end;

  modport source (output valid, sample, sensor_pos, frame_end, input ready);
  modport sink (input valid, sample, sensor_pos, frame_end, output ready);
endinterface

interface lsps_res_if #(
  parameter int DUTY_W = lsps_pkg::DUTY_BITS
);
  import lsps_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [DUTY_W-1:0]        left_duty;
  logic [DUTY_W-1:0]        right_duty;
  logic signed [SUM_W-1:0]  position_sum;
  logic                     line_held;

  modport source (output valid, left_duty, right_duty, position_sum, line_held, input ready);
  modport sink (input valid, left_duty, right_duty, position_sum, line_held, output ready);
endinterface

FILE: rtl/line_sensor_pid_steering_core.sv
// Top level of the line-sensor PID steering core: frame accumulation, PID pipeline, duty output.
//
// Reflectance samples arrive one per transfer, each tagged with its sensor position; the core
// takes one sample every clock cycle unless the sample channel stalls. A sample below
// white_threshold at a valid sensor position adds its position offset from the array center to
// a saturating frame sum. The sample that carries frame_end closes the frame: the sum (or the
// last nonzero sum when the frame sum is zero) is used as the position, the derivative and
// saturating integral terms are formed, and the frame enters a six-stage pipeline (gain
// multiplies, sum, magnitude, divide by 13 through a reciprocal multiply, duty saturation).
// Empty pipeline stages keep taking frames while a result waits; the sample channel stalls only
// when every pipeline stage holds a frame and the result is not taken. Configuration writes are
// taken at any edge with cfg_write high and rst low and apply at once.
module line_sensor_pid_steering_core #(
  parameter int DUTY_BITS = lsps_pkg::DUTY_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [lsps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsps_pkg::CFG_DATA_W-1:0] cfg_data,
  lsps_smp_if.sink                        smp,
  lsps_res_if.source                      res
);
  import lsps_pkg::*;

  localparam int STAGES = 6;
  // A correction of 2**CORR_W or more drives both duties to their limits for any base duty.
  localparam int CORR_W = (DUTY_BITS > BASE_W) ? DUTY_BITS : BASE_W;
  localparam int DIV_BITS = CORR_W + 4;
  localparam int DIV_SHIFT = DIV_BITS + 4;
  localparam int DIV_MULT = (2 ** DIV_SHIFT + DIVISOR - 1) / DIVISOR;
  localparam int MULT_W = DIV_BITS + 1;
  localparam int DIV_LIMIT = DIVISOR * (2 ** CORR_W);
  localparam int PID_W = 42;
  localparam int DUTY_MAX = 2 ** DUTY_BITS - 1;
  localparam int ARITH_W = CORR_W + 3;
  localparam int PROP_W = GAIN_W + 1 + SUM_W;
  localparam int DER_W = GAIN_W + 1 + SUM_W + 1;
  localparam int INT_W = GAIN_W + 1 + TOTAL_W;

  localparam logic signed [SUM_W:0] SUM_MAX = (SUM_W + 1)'(2 ** (SUM_W - 1) - 1);
  localparam logic signed [SUM_W:0] SUM_MIN = -(SUM_W + 1)'(2 ** (SUM_W - 1));

  // Configuration registers.
  logic [SAMPLE_W-1:0] white_threshold;
  logic [GAIN_W-1:0]   prop_gain;
  logic [GAIN_W-1:0]   deriv_gain;
  logic [GAIN_W-1:0]   integ_gain;
  logic [BASE_W-1:0]   base_duty;

  always_ff @(posedge clk) begin
    if (rst) begin
      white_threshold <= WHITE_THRESHOLD_RESET;
      prop_gain <= PROP_GAIN_RESET;
      deriv_gain <= DERIV_GAIN_RESET;
      integ_gain <= INTEG_GAIN_RESET;
      base_duty <= BASE_DUTY_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_WHITE_THRESHOLD: white_threshold <= cfg_data[SAMPLE_W-1:0];
        CFG_PROP_GAIN:       prop_gain <= cfg_data[GAIN_W-1:0];
        CFG_DERIV_GAIN:      deriv_gain <= cfg_data[GAIN_W-1:0];
        CFG_INTEG_GAIN:      integ_gain <= cfg_data[GAIN_W-1:0];
        CFG_BASE_DUTY:       base_duty <= cfg_data[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage can load when it is empty or its content moves on.
  logic [STAGES:1] vld;
  logic [STAGES:1] free;
  logic            in_xfer;

  always_comb begin
    free[STAGES] = !vld[STAGES] || res.ready;
    for (int k = STAGES - 1; k >= 1; k--) begin
      free[k] = !vld[k] || free[k + 1];
    end
  end

  assign smp.ready = free[1];
  assign in_xfer = smp.valid && smp.ready;

  // Frame state and the work done on the transfer of each sample.
  logic signed [SUM_W-1:0]   frame_sum;
  logic signed [SUM_W-1:0]   held_sum;
  logic signed [SUM_W-1:0]   previous_sum;
  logic signed [TOTAL_W-1:0] error_total;

  logic                      hit;
  logic signed [SUM_W:0]     delta;
  logic signed [SUM_W:0]     sum_ext;
  logic signed [SUM_W-1:0]   sum_sat;
  logic signed [SUM_W-1:0]   used;
  logic                      held;
  logic signed [SUM_W:0]     deriv;
  logic signed [TOTAL_W:0]   total_ext;
  logic signed [TOTAL_W-1:0] total_sat;

  always_comb begin
    hit = ((POS_W + 1)'(smp.sensor_pos) < (POS_W + 1)'(NUM_SENSORS))
          && (smp.sample < white_threshold);
    delta = $signed((SUM_W + 1)'(smp.sensor_pos)) - (SUM_W + 1)'(CENTER);
    sum_ext = (SUM_W + 1)'(frame_sum) + (hit ? delta : '0);
    if (sum_ext > SUM_MAX) begin
      sum_sat = SUM_MAX[SUM_W-1:0];
    end else if (sum_ext < SUM_MIN) begin
      sum_sat = SUM_MIN[SUM_W-1:0];
    end else begin
      sum_sat = sum_ext[SUM_W-1:0];
    end

    held = (sum_sat == '0);
    used = held ? held_sum : sum_sat;
    deriv = (SUM_W + 1)'(used) - (SUM_W + 1)'(previous_sum);

    total_ext = (TOTAL_W + 1)'(error_total) + (TOTAL_W + 1)'(used);
    if (total_ext[TOTAL_W] != total_ext[TOTAL_W-1]) begin
      total_sat = {total_ext[TOTAL_W], {(TOTAL_W - 1){!total_ext[TOTAL_W]}}};
    end else begin
      total_sat = total_ext[TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_sum <= '0;
      held_sum <= '0;
      previous_sum <= '0;
      error_total <= '0;
    end else if (in_xfer) begin
      if (smp.frame_end) begin
        frame_sum <= '0;
        held_sum <= used;
        previous_sum <= used;
        error_total <= total_sat;
      end else begin
        frame_sum <= sum_sat;
      end
    end
  end

  // Position and held flag travel with each frame through all stages.
  logic signed [SUM_W-1:0] pos_pipe [1:STAGES];
  logic                    held_pipe [1:STAGES];

  // Stage 1: controller inputs.
  logic signed [SUM_W:0]     deriv1;
  logic signed [TOTAL_W-1:0] total1;
  // Stage 2: gain products.
  logic signed [PROP_W-1:0]  prop_p;
  logic signed [DER_W-1:0]   der_p;
  logic signed [INT_W-1:0]   int_p;
  // Stage 3: PID sum.
  logic signed [PID_W-1:0]   pid;
  // Stage 4: magnitude and sign.
  logic [PID_W-2:0]          mag;
  logic                      neg4;
  // Stage 5: correction magnitude, saturated.
  logic [CORR_W:0]           corr_mag;
  logic                      neg5;
  // Stage 6: output register.
  logic [DUTY_BITS-1:0]      left_duty;
  logic [DUTY_BITS-1:0]      right_duty;

  logic signed [PID_W-1:0]         pid_abs;
  logic [DIV_BITS+MULT_W-1:0]      quot_prod;
  logic                            corr_sat;
  logic signed [ARITH_W-1:0]       corr_s;
  logic signed [ARITH_W-1:0]       base_s;
  logic signed [ARITH_W-1:0]       left_raw;
  logic signed [ARITH_W-1:0]       right_raw;
  logic [DUTY_BITS-1:0]            left_next;
  logic [DUTY_BITS-1:0]            right_next;

  always_comb begin
    pid_abs = pid[PID_W-1] ? -pid : pid;
    quot_prod = (DIV_BITS + MULT_W)'(mag[DIV_BITS-1:0]) * (DIV_BITS + MULT_W)'(DIV_MULT);
    corr_sat = mag >= (PID_W - 1)'(DIV_LIMIT);

    base_s = $signed(ARITH_W'(base_duty));
    corr_s = neg5 ? -$signed(ARITH_W'(corr_mag)) : $signed(ARITH_W'(corr_mag));
    left_raw = base_s - corr_s;
    right_raw = base_s + corr_s;
    if (left_raw < 0) begin
      left_next = '0;
    end else if (left_raw > ARITH_W'(DUTY_MAX)) begin
      left_next = DUTY_BITS'(DUTY_MAX);
    end else begin
      left_next = left_raw[DUTY_BITS-1:0];
    end
    if (right_raw < 0) begin
      right_next = '0;
    end else if (right_raw > ARITH_W'(DUTY_MAX)) begin
      right_next = DUTY_BITS'(DUTY_MAX);
    end else begin
      right_next = right_raw[DUTY_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (free[1]) begin
        vld[1] <= in_xfer && smp.frame_end;
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (free[k]) begin
          vld[k] <= vld[k - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free[1]) begin
      pos_pipe[1] <= used;
      held_pipe[1] <= held;
      deriv1 <= deriv;
      total1 <= total_sat;
    end
    for (int k = 2; k <= STAGES; k++) begin
      if (free[k]) begin
        pos_pipe[k] <= pos_pipe[k - 1];
        held_pipe[k] <= held_pipe[k - 1];
      end
    end
    if (free[2]) begin
      prop_p <= $signed({1'b0, prop_gain}) * pos_pipe[1];
      der_p <= $signed({1'b0, deriv_gain}) * deriv1;
      int_p <= $signed({1'b0, integ_gain}) * total1;
    end
    if (free[3]) begin
      pid <= PID_W'(prop_p) + PID_W'(der_p) + PID_W'(int_p);
    end
    if (free[4]) begin
      mag <= pid_abs[PID_W-2:0];
      neg4 <= pid[PID_W-1];
    end
    if (free[5]) begin
      corr_mag <= corr_sat ? (CORR_W + 1)'(2 ** CORR_W)
                           : {1'b0, quot_prod[DIV_SHIFT +: CORR_W]};
      neg5 <= neg4;
    end
    if (free[6]) begin
      left_duty <= left_next;
      right_duty <= right_next;
    end
  end

  assign res.valid = vld[STAGES];
  assign res.left_duty = left_duty;
  assign res.right_duty = right_duty;
  assign res.position_sum = pos_pipe[STAGES];
  assign res.line_held = held_pipe[STAGES];

  // A frame reported as fresh must carry a nonzero position.
  a_fresh_nonzero: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.line_held || res.position_sum != '0))
    else $error("fresh frame result with zero position sum");

  // Closing a frame clears the running sum for the next one.
  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    in_xfer && smp.frame_end |=> frame_sum == '0)
    else $error("frame sum not cleared after frame end");

  // Samples inside a frame leave the per-frame controller state alone.
  a_mid_frame_state: assert property (@(posedge clk) disable iff (rst)
    in_xfer && !smp.frame_end |=> $stable(previous_sum) && $stable(error_total))
    else $error("controller state changed mid-frame");

  // The sample channel stalls only when every stage is full and the result is not taken.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !smp.ready |-> (&vld) && !res.ready)
    else $error("sample channel stalled with a free pipeline stage");

endmodule
